@@ rtl/bezinv_pkg.sv @@
// Shared constants and codes for the quadratic Bezier inverse parameter solver.
package bezinv_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int POINT_WIDTH_DEF   = 16;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_DEGENERATE = 2'd1,
		ST_NEG_DISC   = 2'd2,
		ST_SATURATED  = 2'd3
	} solve_status_t;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_START  = 2'd0,
		REG_MIDDLE = 2'd1,
		REG_END    = 2'd2
	} reg_index_t;

endpackage

@@ rtl/bezinv_sqrt_cell.sv @@
// One cell of the square root chain: resolves one root bit per word.
module bezinv_sqrt_cell #(
	parameter int RB = 34,
	parameter int SW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [2*RB-1:0]    in_rad,
	input  logic [RB-1:0]      in_root,
	input  logic [RB+1:0]      in_rem,
	input  logic [SW-1:0]      in_side,
	output logic               out_valid,
	output logic [2*RB-1:0]    out_rad,
	output logic [RB-1:0]      out_root,
	output logic [RB+1:0]      out_rem,
	output logic [SW-1:0]      out_side
);

	logic [RB+3:0] cur;
	logic [RB+3:0] trial;
	logic          ge;
	logic [RB+3:0] diff;

	// Bring down the next radicand pair and try the next root bit
	always_comb begin
		cur   = {in_rem, in_rad[2*RB-1 -: 2]};
		trial = {2'b00, in_root, 2'b01};
		ge    = (cur >= trial);
		diff  = cur - trial;
	end

	// Hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	// Advance the partial root, remainder and radicand
	always_ff @(posedge clk) begin
		if (adv) begin
			out_rad  <= {in_rad[2*RB-3:0], 2'b00};
			out_root <= {in_root[RB-2:0], ge};
			out_rem  <= ge ? diff[RB+1:0] : cur[RB+1:0];
			out_side <= in_side;
		end
	end

endmodule

@@ rtl/bezinv_div_cell.sv @@
// One cell of the restoring divider chain: resolves one quotient bit per word.
module bezinv_div_cell #(
	parameter int NW  = 35,
	parameter int DVW = 19,
	parameter int SW  = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  logic [NW-1:0]   in_nq,
	input  logic [DVW-1:0]  in_rem,
	input  logic [DVW-1:0]  in_div,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [NW-1:0]   out_nq,
	output logic [DVW-1:0]  out_rem,
	output logic [DVW-1:0]  out_div,
	output logic [SW-1:0]   out_side
);

	logic [DVW:0] cur;
	logic [DVW:0] diff;
	logic         ge;

	// Shift in the next numerator bit and compare against the divisor
	always_comb begin
		cur  = {in_rem, in_nq[NW-1]};
		ge   = (cur >= {1'b0, in_div});
		diff = cur - {1'b0, in_div};
	end

	// Hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	// Advance remainder; quotient bits enter where numerator bits leave
	always_ff @(posedge clk) begin
		if (adv) begin
			out_nq   <= {in_nq[NW-2:0], ge};
			out_rem  <= ge ? diff[DVW-1:0] : cur[DVW-1:0];
			out_div  <= in_div;
			out_side <= in_side;
		end
	end

endmodule

@@ rtl/quadratic_bezier_inverse_parameter_top.sv @@
// Quadratic Bezier inverse parameter solver: config registers and solve pipeline.
//
// Solves alpha*t^2 + beta*t + gamma = 0 for each target word and returns t as a
// signed fixed point value with FRACTION_BITS fraction bits, plus a status code.
// One target is taken every cycle while the output is not stalled. The square root
// cell chain has length RB = POINT_WIDTH + FRACTION_BITS + 2 (one root bit per
// cell) and the divider cell chain has length NW = POINT_WIDTH + FRACTION_BITS + 3
// (one quotient bit per cell).
// The whole pipeline holds while a finished result is waiting and not taken.
// Control values are to be written over the APB port only while no target is in flight; the block does not enforce it.
module quadratic_bezier_inverse_parameter_top #(
	parameter int FRACTION_BITS = bezinv_pkg::FRACTION_BITS_DEF,
	parameter int POINT_WIDTH   = bezinv_pkg::POINT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          target_valid,
	output logic                          target_ready,
	input  logic signed [POINT_WIDTH-1:0] target_value,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [31:0]            parameter_t,
	output logic [1:0]                    solve_status
);

	import bezinv_pkg::*;

	localparam int P   = POINT_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int AW  = P + 2;
	localparam int GW  = P + 1;
	localparam int DSW = 2 * P + 5;
	localparam int DW  = 2 * P + 4;
	localparam int RB  = P + F + 2;
	localparam int NW  = P + F + 3;
	localparam int DVW = P + 3;
	localparam int SW  = 3 + AW + AW + GW;
	localparam int DSIDE = 3;
	localparam int CW  = (NW >= 33) ? NW + 1 : 34;
	localparam logic [CW-1:0] MAX_POS = CW'(64'h7fff_ffff);
	localparam logic [CW-1:0] MAX_NEG = CW'(64'h8000_0000);

	logic signed [P-1:0] start_q, middle_q, end_q;
	logic                cfg_we;
	logic                adv;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			middle_q <= '0;
			end_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(paddr[3:2]))
				REG_START:  start_q  <= pwdata[P-1:0];
				REG_MIDDLE: middle_q <= pwdata[P-1:0];
				REG_END:    end_q    <= pwdata[P-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index_t'(paddr[3:2]))
			REG_START:  prdata = 32'(start_q);
			REG_MIDDLE: prdata = 32'(middle_q);
			REG_END:    prdata = 32'(end_q);
			default:    prdata = '0;
		endcase
	end

	// Whole pipeline moves unless a result is stuck at the output
	assign adv          = !result_valid || result_ready;
	assign target_ready = adv;

	// Stage 1: curve coefficients
	logic                 v_s1;
	logic signed [AW-1:0] alpha_s1, beta_s1;
	logic signed [GW-1:0] gamma_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= target_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s1 <= AW'(start_q) - (AW'(middle_q) <<< 1) + AW'(end_q);
			beta_s1  <= (AW'(middle_q) - AW'(start_q)) <<< 1;
			gamma_s1 <= GW'(start_q) - GW'(target_value);
		end
	end

	// Stage 2: products for the discriminant
	logic                      v_s2;
	logic signed [2*AW-1:0]    bb_s2;
	logic signed [AW+GW-1:0]   ag_s2;
	logic signed [AW-1:0]      alpha_s2, beta_s2;
	logic signed [GW-1:0]      gamma_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s2    <= beta_s1 * beta_s1;
			ag_s2    <= alpha_s1 * gamma_s1;
			alpha_s2 <= alpha_s1;
			beta_s2  <= beta_s1;
			gamma_s2 <= gamma_s1;
		end
	end

	// Stage 3: discriminant and case selection
	logic signed [DSW-1:0] disc;
	logic                  v_s3;
	logic [2*RB-1:0]       rad_s3;
	logic [SW-1:0]         side_s3;
	logic                  lin;
	solve_status_t         st_pre;

	always_comb begin
		disc = DSW'(bb_s2) - (DSW'(ag_s2) <<< 2);
		lin  = (alpha_s2 == '0);
		if (lin) begin
			st_pre = (beta_s2 == '0) ? ST_DEGENERATE : ST_OK;
		end else begin
			st_pre = disc[DSW-1] ? ST_NEG_DISC : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= {disc[DW-1:0], {(2*F){1'b0}}};
			side_s3 <= {lin, st_pre, alpha_s2, beta_s2, gamma_s2};
		end
	end

	// Square root cell chain
	logic              sq_valid [0:RB];
	logic [2*RB-1:0]   sq_rad   [0:RB];
	logic [RB-1:0]     sq_root  [0:RB];
	logic [RB+1:0]     sq_rem   [0:RB];
	logic [SW-1:0]     sq_side  [0:RB];

	assign sq_valid[0] = v_s3;
	assign sq_rad[0]   = rad_s3;
	assign sq_root[0]  = '0;
	assign sq_rem[0]   = '0;
	assign sq_side[0]  = side_s3;

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		bezinv_sqrt_cell #(.RB(RB), .SW(SW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (sq_valid[i]),
			.in_rad   (sq_rad[i]),
			.in_root  (sq_root[i]),
			.in_rem   (sq_rem[i]),
			.in_side  (sq_side[i]),
			.out_valid(sq_valid[i+1]),
			.out_rad  (sq_rad[i+1]),
			.out_root (sq_root[i+1]),
			.out_rem  (sq_rem[i+1]),
			.out_side (sq_side[i+1])
		);
	end

	// Stage 4: numerator and divisor as sign and magnitude
	logic                  sq_lin;
	logic [1:0]            sq_st;
	logic signed [AW-1:0]  sq_alpha, sq_beta;
	logic signed [GW-1:0]  sq_gamma;
	logic signed [NW:0]    num;
	logic signed [DVW:0]   dvs;
	logic [NW:0]           num_abs;
	logic [DVW:0]          dvs_abs;

	assign {sq_lin, sq_st, sq_alpha, sq_beta, sq_gamma} = sq_side[RB];

	always_comb begin
		if (sq_lin) begin
			num = -((NW + 1)'(sq_gamma) <<< F);
			dvs = (DVW + 1)'(sq_beta);
		end else begin
			num = -((NW + 1)'(sq_beta) <<< F) + $signed((NW + 1)'(sq_root[RB]));
			dvs = (DVW + 1)'(sq_alpha) <<< 1;
		end
		num_abs = num[NW] ? -num : num;
		dvs_abs = dvs[DVW] ? -dvs : dvs;
	end

	logic              v_s4;
	logic [NW-1:0]     num_s4;
	logic [DVW-1:0]    div_s4;
	logic [DSIDE-1:0]  dside_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_valid[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4   <= num_abs[NW-1:0];
			div_s4   <= dvs_abs[DVW-1:0];
			dside_s4 <= {num[NW] ^ dvs[DVW], sq_st};
		end
	end

	// Divider cell chain
	logic              dv_valid [0:NW];
	logic [NW-1:0]     dv_nq    [0:NW];
	logic [DVW-1:0]    dv_rem   [0:NW];
	logic [DVW-1:0]    dv_div   [0:NW];
	logic [DSIDE-1:0]  dv_side  [0:NW];

	assign dv_valid[0] = v_s4;
	assign dv_nq[0]    = num_s4;
	assign dv_rem[0]   = '0;
	assign dv_div[0]   = div_s4;
	assign dv_side[0]  = dside_s4;

	for (genvar j = 0; j < NW; j++) begin : g_div
		bezinv_div_cell #(.NW(NW), .DVW(DVW), .SW(DSIDE)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (dv_valid[j]),
			.in_nq    (dv_nq[j]),
			.in_rem   (dv_rem[j]),
			.in_div   (dv_div[j]),
			.in_side  (dv_side[j]),
			.out_valid(dv_valid[j+1]),
			.out_nq   (dv_nq[j+1]),
			.out_rem  (dv_rem[j+1]),
			.out_div  (dv_div[j+1]),
			.out_side (dv_side[j+1])
		);
	end

	// Stage 5: apply sign, clamp, and drop special cases to zero
	logic          q_neg;
	logic [1:0]    q_st;
	logic [CW-1:0] q_ext;
	logic [CW-1:0] q_neg_val;
	logic [31:0]   t_next;
	logic [1:0]    st_next;

	assign {q_neg, q_st} = dv_side[NW];

	always_comb begin
		q_ext     = CW'(dv_nq[NW]);
		q_neg_val = -q_ext;
		if (q_st != ST_OK) begin
			t_next  = '0;
			st_next = q_st;
		end else if (!q_neg && q_ext > MAX_POS) begin
			t_next  = 32'h7fff_ffff;
			st_next = ST_SATURATED;
		end else if (q_neg && q_ext > MAX_NEG) begin
			t_next  = 32'h8000_0000;
			st_next = ST_SATURATED;
		end else begin
			t_next  = q_neg ? q_neg_val[31:0] : q_ext[31:0];
			st_next = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= dv_valid[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			parameter_t  <= t_next;
			solve_status <= st_next;
		end
	end

`ifndef SYNTHESIS
	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (solve_status == ST_DEGENERATE || solve_status == ST_NEG_DISC)
		|-> parameter_t == 32'sd0)
		else $error("special case result not zero");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && solve_status == ST_SATURATED
		|-> (parameter_t == 32'sh7fff_ffff || parameter_t == 32'sh8000_0000))
		else $error("saturated result not at a range limit");

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !target_ready)
		else $error("target taken while output is stalled");
`endif

endmodule
